### rtl/sm4_pkg.sv
// sm4 shared definitions: s-box table, fk/ck constants, linear transforms,
// register indexes and the command/status structs between controller and datapath
// depends on nothing
`timescale 1ns / 1ps

package sm4_pkg;

  localparam int ROUNDS = 32;
  localparam int RK_AW  = $clog2(ROUNDS);

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_KEY_HIGH   = 3'd0,
    REG_KEY_LOW    = 3'd1,
    REG_IV_HIGH    = 3'd2,
    REG_IV_LOW     = 3'd3,
    REG_CHAIN_MODE = 3'd4,
    REG_DIRECTION  = 3'd5
  } cfg_reg_t;

  // controller to datapath
  typedef struct packed {
    logic             load;      // latch accepted item, seed key words
    logic             key_step;  // one key schedule step, write round key idx
    logic             key_done;  // last key schedule step
    logic             round;     // one cipher round with the fetched round key
    logic             finish;    // move result to output register
    logic [RK_AW-1:0] idx;       // key schedule step number
    logic [RK_AW-1:0] rd_idx;    // round number whose key is fetched now
  } sm4_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic keys_ready;
    logic out_busy;
  } sm4_status_t;

  localparam logic [31:0] FK0 = 32'hA3B1BAC6;
  localparam logic [31:0] FK1 = 32'h56AA3350;
  localparam logic [31:0] FK2 = 32'h677D9197;
  localparam logic [31:0] FK3 = 32'hB27022DC;

  localparam logic [7:0] SBOX [0:255] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7,
    8'h16, 8'hB6, 8'h14, 8'hC2, 8'h28, 8'hFB, 8'h2C, 8'h05,
    8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
    8'h9C, 8'h42, 8'h50, 8'hF4, 8'h91, 8'hEF, 8'h98, 8'h7A,
    8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95,
    8'h80, 8'hDF, 8'h94, 8'hFA, 8'h75, 8'h8F, 8'h3F, 8'hA6,
    8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8,
    8'h68, 8'h6B, 8'h81, 8'hB2, 8'h71, 8'h64, 8'hDA, 8'h8B,
    8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2,
    8'h25, 8'h22, 8'h7C, 8'h3B, 8'h01, 8'h21, 8'h78, 8'h87,
    8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E,
    8'hEA, 8'hBF, 8'h8A, 8'hD2, 8'h40, 8'hC7, 8'h38, 8'hB5,
    8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55,
    8'hAD, 8'h93, 8'h32, 8'h30, 8'hF5, 8'h8C, 8'hB1, 8'hE3,
    8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F,
    8'hD5, 8'hDB, 8'h37, 8'h45, 8'hDE, 8'hFD, 8'h8E, 8'h2F,
    8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F,
    8'h11, 8'hD9, 8'h5C, 8'h41, 8'h1F, 8'h10, 8'h5A, 8'hD8,
    8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0,
    8'h89, 8'h69, 8'h97, 8'h4A, 8'h0C, 8'h96, 8'h77, 8'h7E,
    8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20,
    8'h79, 8'hEE, 8'h5F, 8'h3E, 8'hD7, 8'hCB, 8'h39, 8'h48
  };

  // byte-wise s-box on a word
  function automatic logic [31:0] sbox32(input logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // cipher diffusion
  function automatic logic [31:0] lin_l(input logic [31:0] t);
    return t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
  endfunction

  // key schedule diffusion
  function automatic logic [31:0] lin_lp(input logic [31:0] t);
    return t ^ rotl(t, 13) ^ rotl(t, 23);
  endfunction

  // ck word i: bytes are (4i+j)*7 mod 256
  function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] i);
    logic [31:0] w;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      w = {w[23:0], 8'((4 * int'(i) + j) * 7)};
    end
    return w;
  endfunction

endpackage

### rtl/sm4_ram.sv
// generic single-write, single-read ram with registered read data
// depends on nothing
`timescale 1ns / 1ps

module sm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sm4_ctrl.sv
// sm4 controller: sequences key schedule, round key fetch, rounds and writeback
// depends on sm4_pkg
`timescale 1ns / 1ps

module sm4_ctrl
  import sm4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  sm4_status_t status,
  output sm4_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEYGEN,
    S_PREP,
    S_ROUND,
    S_DONE
  } state_t;

  localparam logic [RK_AW-1:0] LAST_IDX = RK_AW'(ROUNDS - 1);

  state_t           state;
  logic [RK_AW-1:0] cnt;
  logic             accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.idx      = cnt;
    cmd.rd_idx   = cnt + RK_AW'(1);
    cmd.load     = accept;
    case (state)
      S_KEYGEN: begin
        cmd.key_step = 1'b1;
        cmd.key_done = (cnt == LAST_IDX);
      end
      S_PREP:  cmd.rd_idx = '0;
      S_ROUND: cmd.round = 1'b1;
      S_DONE:  cmd.finish = !status.out_busy;
      default: ;
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            state <= status.keys_ready ? S_PREP : S_KEYGEN;
          end
        end
        S_KEYGEN: begin
          cnt <= cnt + RK_AW'(1);
          if (cnt == LAST_IDX) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          cnt   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          cnt <= cnt + RK_AW'(1);
          if (cnt == LAST_IDX) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!status.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // stale keys always go through the schedule first
  a_keygen_when_stale: assert property (@(posedge clk) disable iff (rst)
    (accept && !status.keys_ready) |=> (state == S_KEYGEN))
    else $error("item started without key schedule");

  // rounds only ever run on derived keys
  a_round_keys_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.round |-> status.keys_ready)
    else $error("round issued with stale keys");

  // the last round hands over to writeback
  a_round_then_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && cnt == LAST_IDX) |=> (state == S_DONE))
    else $error("round sequence did not end in writeback");

  // result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !status.out_busy)
    else $error("result written into busy output register");

endmodule

### rtl/sm4_datapath.sv
// sm4 datapath: config registers, key schedule step, round unit, cbc chain,
// round key ram and output register
// depends on sm4_pkg, sm4_ram
`timescale 1ns / 1ps

module sm4_datapath
  import sm4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sm4_cmd_t    cmd,
  output sm4_status_t status,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  input  logic        last_block,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  output logic        out_last
);

  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic        chain_mode, direction;
  logic        keys_ready;
  logic [63:0] chain_high, chain_low;
  logic        at_message_start;

  // per-item working registers
  logic [31:0] x0, x1, x2, x3;
  logic [31:0] k0, k1, k2, k3;
  logic [63:0] fb_high, fb_low;
  logic [63:0] in_high, in_low;
  logic        in_last;

  logic [63:0] fh, fl;
  logic [31:0] rk;
  logic [31:0] key_t, key_nk;
  logic [31:0] rnd_t, rnd_nx;
  logic [RK_AW-1:0] raddr;
  logic [63:0] res_high, res_low;

  assign status.keys_ready = keys_ready;
  assign status.out_busy   = out_valid && !out_ready;

  // configuration writes and key staleness
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high   <= '0;
      key_low    <= '0;
      iv_high    <= '0;
      iv_low     <= '0;
      chain_mode <= 1'b0;
      direction  <= 1'b0;
      keys_ready <= 1'b0;
    end else begin
      if (cmd.key_done) begin
        keys_ready <= 1'b1;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_KEY_HIGH: begin
            key_high   <= cfg_data;
            keys_ready <= 1'b0;
          end
          REG_KEY_LOW: begin
            key_low    <= cfg_data;
            keys_ready <= 1'b0;
          end
          REG_IV_HIGH:    iv_high    <= cfg_data;
          REG_IV_LOW:     iv_low     <= cfg_data;
          REG_CHAIN_MODE: chain_mode <= cfg_data[0];
          REG_DIRECTION:  direction  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // cbc feedback source
  assign fh = at_message_start ? iv_high : chain_high;
  assign fl = at_message_start ? iv_low  : chain_low;

  // key schedule step
  assign key_t  = sbox32(k1 ^ k2 ^ k3 ^ ck_word(cmd.idx));
  assign key_nk = k0 ^ lin_lp(key_t);

  // cipher round
  assign rnd_t  = sbox32(x1 ^ x2 ^ x3 ^ rk);
  assign rnd_nx = x0 ^ lin_l(rnd_t);

  // decryption walks the round keys backwards
  assign raddr = direction ? (RK_AW'(ROUNDS - 1) - cmd.rd_idx) : cmd.rd_idx;

  sm4_ram #(
    .WIDTH(32),
    .DEPTH(ROUNDS)
  ) u_rk_ram (
    .clk  (clk),
    .we   (cmd.key_step),
    .waddr(cmd.idx),
    .wdata(key_nk),
    .raddr(raddr),
    .rdata(rk)
  );

  // item load, key schedule and round shifting
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_high <= block_high;
      in_low  <= block_low;
      in_last <= last_block;
      fb_high <= fh;
      fb_low  <= fl;
      if (chain_mode && !direction) begin
        {x0, x1} <= block_high ^ fh;
        {x2, x3} <= block_low ^ fl;
      end else begin
        {x0, x1} <= block_high;
        {x2, x3} <= block_low;
      end
      k0 <= key_high[63:32] ^ FK0;
      k1 <= key_high[31:0]  ^ FK1;
      k2 <= key_low[63:32]  ^ FK2;
      k3 <= key_low[31:0]   ^ FK3;
    end
    if (cmd.key_step) begin
      k0 <= k1;
      k1 <= k2;
      k2 <= k3;
      k3 <= key_nk;
    end
    if (cmd.round) begin
      x0 <= x1;
      x1 <= x2;
      x2 <= x3;
      x3 <= rnd_nx;
    end
  end

  // reverse word order, cbc decrypt output whitening
  always_comb begin
    res_high = {x3, x2};
    res_low  = {x1, x0};
    if (chain_mode && direction) begin
      res_high = res_high ^ fb_high;
      res_low  = res_low ^ fb_low;
    end
  end

  // chain state
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_high       <= '0;
      chain_low        <= '0;
      at_message_start <= 1'b1;
    end else if (cmd.finish) begin
      at_message_start <= in_last;
      if (chain_mode) begin
        chain_high <= direction ? in_high : res_high;
        chain_low  <= direction ? in_low  : res_low;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_high <= res_high;
      out_low  <= res_low;
      out_last <= in_last;
    end
  end

endmodule

### rtl/sm4_block_cipher_ecb_cbc_core.sv
// sm4 block cipher core, ecb or cbc, top level
// depends on sm4_pkg, sm4_ctrl, sm4_datapath (which holds sm4_ram)
`timescale 1ns / 1ps

// One 128-bit block per item is ciphered with SM4 (32 rounds), in ECB or CBC
// mode, encrypting or decrypting as set in the configuration registers. The
// core takes one item at a time: from acceptance it fetches the first round
// key from the round key ram, runs the rounds in the single shared round unit
// and writes the result to the output register once the output register is
// free, and accepts a new item only after that write. After a write to either
// key register the next item first runs the key schedule, one round key per
// cycle into the ram. A block with tlast set makes the next block restart the
// chain from the IV. The user must write configuration only while no item is
// in flight; the core itself does not enforce this. cfg_ready is always high and
// indexes past the last register are ignored.

module sm4_block_cipher_ecb_cbc_core
  import sm4_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  // input blocks
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // [63:0] block_high, [127:64] block_low
  input  logic         s_axis_tlast,   // last_block
  // result blocks
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [63:0] out_high, [127:64] out_low
  output logic         m_axis_tlast,   // out_last
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  sm4_cmd_t    cmd;
  sm4_status_t status;

  assign cfg_ready = 1'b1;

  sm4_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  sm4_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .block_high(s_axis_tdata[63:0]),
    .block_low (s_axis_tdata[127:64]),
    .last_block(s_axis_tlast),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_high  (m_axis_tdata[63:0]),
    .out_low   (m_axis_tdata[127:64]),
    .out_last  (m_axis_tlast)
  );

endmodule

### tb/sm4_block_cipher_ecb_cbc_core_tb.sv
// self-checking testbench for the sm4 ecb/cbc core: directed table, then random messages
// depends on sm4_pkg (s-box, fk constants, register indexes) and sm4_block_cipher_ecb_cbc_core
`timescale 1ns / 1ps

module sm4_block_cipher_ecb_cbc_core_tb;
  import sm4_pkg::*;

  localparam int          RANDOM_ITEMS = 1200;
  localparam int          CYCLE_LIMIT  = 2000000;
  localparam logic [2:0]  REG_SPARE_6  = 3'd6;
  localparam logic [2:0]  REG_SPARE_7  = 3'd7;
  localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic {ROW_CFG, ROW_BLOCK} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [63:0] a;       // register data, or block_high
    logic [63:0] b;       // block_low
    logic        last;
    logic        typed;   // expected block written into the row
    logic [63:0] exp_hi;
    logic [63:0] exp_lo;
  } stim_row_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
  } cipher_block_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // [63:0] block_high, [127:64] block_low
  logic         s_axis_tlast;   // last_block
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // [63:0] out_high, [127:64] out_low
  logic         m_axis_tlast;   // out_last
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [63:0]  cfg_data;

  sm4_block_cipher_ecb_cbc_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // predictor state and configuration copy
  logic [63:0]   key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
  logic          cbc_on, decrypting;
  logic [31:0]   round_key [32];
  logic          round_keys_valid;
  logic [63:0]   chain_hi, chain_lo;
  logic          chain_at_start;

  cipher_block_t pending_blocks [$];
  stim_row_t     directed_rows [$];
  int            errors;
  int            idle_pct;
  int            stall_pct;
  int            cycle_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sm4_block_cipher_ecb_cbc_core: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [31:0] rol32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // schedule constant: byte j of word i is (4i+j)*7 mod 256
  function automatic logic [31:0] sched_const(input int i);
    logic [31:0] w;
    int          bv;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      bv = ((4 * i + j) * 7) % 256;
      w  = {w[23:0], bv[7:0]};
    end
    return w;
  endfunction

  task automatic expand_key();
    logic [31:0] k [4];
    logic [31:0] t, nk;
    k[0] = key_hi_q[63:32] ^ FK0;
    k[1] = key_hi_q[31:0]  ^ FK1;
    k[2] = key_lo_q[63:32] ^ FK2;
    k[3] = key_lo_q[31:0]  ^ FK3;
    for (int i = 0; i < 32; i++) begin
      t  = sub_word(k[1] ^ k[2] ^ k[3] ^ sched_const(i));
      nk = k[0] ^ t ^ rol32(t, 13) ^ rol32(t, 23);
      round_key[i] = nk;
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
    end
    round_keys_valid = 1'b1;
  endtask

  // 32 rounds, keys reversed for decryption; returns {out_high, out_low}
  function automatic logic [127:0] sm4_rounds(input logic [63:0] hi, input logic [63:0] lo,
                                               input logic dec);
    logic [31:0] x0, x1, x2, x3, t, nx, rk;
    x0 = hi[63:32]; x1 = hi[31:0]; x2 = lo[63:32]; x3 = lo[31:0];
    for (int i = 0; i < 32; i++) begin
      rk = dec ? round_key[31 - i] : round_key[i];
      t  = sub_word(x1 ^ x2 ^ x3 ^ rk);
      nx = x0 ^ t ^ rol32(t, 2) ^ rol32(t, 10) ^ rol32(t, 18) ^ rol32(t, 24);
      x0 = x1; x1 = x2; x2 = x3; x3 = nx;
    end
    return {x3, x2, x1, x0};
  endfunction

  task automatic predict_block(input logic [63:0] hi, input logic [63:0] lo, input logic last,
                               output cipher_block_t res);
    logic [127:0] r;
    logic [63:0]  fb_hi, fb_lo;
    if (!round_keys_valid) expand_key();
    fb_hi = chain_at_start ? iv_hi_q : chain_hi;
    fb_lo = chain_at_start ? iv_lo_q : chain_lo;
    if (!cbc_on) begin
      r = sm4_rounds(hi, lo, decrypting);
    end else if (!decrypting) begin
      r = sm4_rounds(hi ^ fb_hi, lo ^ fb_lo, 1'b0);
      chain_hi = r[127:64];
      chain_lo = r[63:0];
    end else begin
      r = sm4_rounds(hi, lo, 1'b1) ^ {fb_hi, fb_lo};
      chain_hi = hi;
      chain_lo = lo;
    end
    chain_at_start = last;
    res.hi   = r[127:64];
    res.lo   = r[63:0];
    res.last = last;
  endtask

  task automatic apply_reg(input logic [2:0] idx, input logic [63:0] data);
    case (idx)
      REG_KEY_HIGH: begin
        key_hi_q = data;
        round_keys_valid = 1'b0;
      end
      REG_KEY_LOW: begin
        key_lo_q = data;
        round_keys_valid = 1'b0;
      end
      REG_IV_HIGH:    iv_hi_q = data;
      REG_IV_LOW:     iv_lo_q = data;
      REG_CHAIN_MODE: cbc_on = data[0];
      REG_DIRECTION:  decrypting = data[0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // present one input item; the expectation is pushed when it is accepted
  task automatic push_block(input logic [63:0] hi, input logic [63:0] lo, input logic last,
                            input logic typed, input logic [63:0] exp_hi,
                            input logic [63:0] exp_lo);
    cipher_block_t res;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {lo, hi};
    s_axis_tlast  = last;
    do @(posedge clk); while (!s_axis_tready);
    predict_block(hi, lo, last, res);
    if (typed) begin
      res.hi = exp_hi;
      res.lo = exp_lo;
    end
    pending_blocks.push_back(res);
  endtask

  // lower valid and wait until the core has nothing in flight
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic add_row(input row_kind_t kind, input logic [2:0] idx, input logic [63:0] a,
                         input logic [63:0] b, input logic last, input logic typed,
                         input logic [63:0] exp_hi, input logic [63:0] exp_lo);
    stim_row_t row;
    row.kind = kind; row.idx = idx; row.a = a; row.b = b; row.last = last;
    row.typed = typed; row.exp_hi = exp_hi; row.exp_lo = exp_lo;
    directed_rows.push_back(row);
  endtask

  // zero, all ones, or random
  function automatic logic [63:0] pick_word();
    int sel;
    sel = $urandom_range(7);
    if (sel == 0) return '0;
    if (sel == 1) return ALL_ONES;
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------- checker
  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %h expected %h", $realtime, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cipher_block_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch("unexpected result block", m_axis_tdata[63:0], '0);
      end else begin
        want = pending_blocks.pop_front();
        if (m_axis_tdata[63:0] !== want.hi)
          report_mismatch("out_high", m_axis_tdata[63:0], want.hi);
        if (m_axis_tdata[127:64] !== want.lo)
          report_mismatch("out_low", m_axis_tdata[127:64], want.lo);
        if (m_axis_tlast !== want.last)
          report_mismatch("out_last", 64'(m_axis_tlast), 64'(want.last));
      end
    end
  end

  // receiver back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_axis_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin
    int random_items;
    int group;
    int msg_len;
    int phase;
    logic broken;

    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_KEY_HIGH;
    cfg_data      = '0;
    errors        = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    key_hi_q = '0; key_lo_q = '0; iv_hi_q = '0; iv_lo_q = '0;
    cbc_on = 1'b0; decrypting = 1'b0;
    round_keys_valid = 1'b0;
    chain_hi = '0; chain_lo = '0;
    chain_at_start = 1'b1;
    for (int i = 0; i < 32; i++) round_key[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset config (zero key), standard vector both ways, cbc, ignored indexes
    add_row(ROW_BLOCK, REG_KEY_HIGH, '0, '0, 1'b1, 1'b0, '0, '0);
    add_row(ROW_BLOCK, REG_KEY_HIGH, ALL_ONES, ALL_ONES, 1'b0, 1'b0, '0, '0);
    add_row(ROW_CFG, REG_KEY_HIGH, 64'h0123456789ABCDEF, '0, 1'b0, 1'b0, '0, '0);
    add_row(ROW_CFG, REG_KEY_LOW, 64'hFEDCBA9876543210, '0, 1'b0, 1'b0, '0, '0);
    add_row(ROW_BLOCK, REG_KEY_HIGH, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 1'b1,
            1'b1, 64'h681EDF34D206965E, 64'h86B3E94F536E4246);
    add_row(ROW_CFG, REG_DIRECTION, 64'd1, '0, 1'b0, 1'b0, '0, '0);
    add_row(ROW_BLOCK, REG_KEY_HIGH, 64'h681EDF34D206965E, 64'h86B3E94F536E4246, 1'b0,
            1'b1, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    add_row(ROW_CFG, REG_CHAIN_MODE, 64'd1, '0, 1'b0, 1'b0, '0, '0);
    add_row(ROW_CFG, REG_IV_HIGH, ALL_ONES, '0, 1'b0, 1'b0, '0, '0);
    add_row(ROW_CFG, REG_IV_LOW, 64'hA5A5A5A5A5A5A5A5, '0, 1'b0, 1'b0, '0, '0);
    add_row(ROW_BLOCK, REG_KEY_HIGH, 64'h1111111111111111, 64'h2222222222222222, 1'b0,
            1'b0, '0, '0);
    add_row(ROW_BLOCK, REG_KEY_HIGH, ALL_ONES, '0, 1'b1, 1'b0, '0, '0);
    add_row(ROW_BLOCK, REG_KEY_HIGH, '0, ALL_ONES, 1'b0, 1'b0, '0, '0);
    add_row(ROW_CFG, REG_DIRECTION, '0, '0, 1'b0, 1'b0, '0, '0);
    add_row(ROW_BLOCK, REG_KEY_HIGH, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 1'b0,
            1'b0, '0, '0);
    add_row(ROW_BLOCK, REG_KEY_HIGH, '0, '0, 1'b1, 1'b0, '0, '0);
    add_row(ROW_CFG, REG_SPARE_6, ALL_ONES, '0, 1'b0, 1'b0, '0, '0);
    add_row(ROW_CFG, REG_SPARE_7, ALL_ONES, '0, 1'b0, 1'b0, '0, '0);
    add_row(ROW_BLOCK, REG_KEY_HIGH, 64'hDEADBEEFCAFEF00D, 64'h0F1E2D3C4B5A6978, 1'b1,
            1'b0, '0, '0);
    add_row(ROW_CFG, REG_KEY_HIGH, ALL_ONES, '0, 1'b0, 1'b0, '0, '0);
    add_row(ROW_CFG, REG_KEY_LOW, '0, '0, 1'b0, 1'b0, '0, '0);
    add_row(ROW_CFG, REG_CHAIN_MODE, '0, '0, 1'b0, 1'b0, '0, '0);
    add_row(ROW_BLOCK, REG_KEY_HIGH, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 1'b1,
            1'b0, '0, '0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(directed_rows[i].idx, directed_rows[i].a);
      end else begin
        push_block(directed_rows[i].a, directed_rows[i].b, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].exp_hi, directed_rows[i].exp_lo);
      end
    end
    drain();

    // random messages, with config changes between them and idling and back-pressure phases in stretches
    random_items = 0;
    group        = 0;
    while (random_items < RANDOM_ITEMS) begin
      phase = (group / 8) % 4;
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase

      // config only between messages, mid-message chain survives non-key writes
      drain();
      if ($urandom_range(99) < 30) write_reg(REG_KEY_HIGH, pick_word());
      if ($urandom_range(99) < 30) write_reg(REG_KEY_LOW, pick_word());
      if ($urandom_range(99) < 40) write_reg(REG_IV_HIGH, pick_word());
      if ($urandom_range(99) < 40) write_reg(REG_IV_LOW, pick_word());
      if ($urandom_range(99) < 50) write_reg(REG_CHAIN_MODE, 64'($urandom_range(1)));
      if ($urandom_range(99) < 50) write_reg(REG_DIRECTION, 64'($urandom_range(1)));
      if ($urandom_range(99) < 10) write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7,
                                             pick_word());

      if ($urandom_range(99) < 10) begin
        // noise: loose blocks with random last flags
        msg_len = $urandom_range(1, 4);
        for (int k = 0; k < msg_len; k++) begin
          push_block(pick_word(), pick_word(), 1'($urandom_range(1)), 1'b0, '0, '0);
        end
      end else begin
        // well-formed message, sometimes cut off without its last block
        msg_len = $urandom_range(1, 8);
        broken  = ($urandom_range(99) < 10);
        for (int k = 0; k < msg_len; k++) begin
          push_block(pick_word(), pick_word(), (k == msg_len - 1) && !broken,
                     1'b0, '0, '0);
        end
      end
      random_items += msg_len;
      group++;
    end

    // wind down
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (pending_blocks.size() != 0)
      report_mismatch("result blocks never arrived", 64'(pending_blocks.size()), '0);
    if (errors == 0) begin
      $display("sm4_block_cipher_ecb_cbc_core: match");
    end else begin
      $display("sm4_block_cipher_ecb_cbc_core: mismatch");
    end
    $finish;
  end

endmodule

### sm4_block_cipher_ecb_cbc_core.f
rtl/sm4_pkg.sv
rtl/sm4_ram.sv
rtl/sm4_ctrl.sv
rtl/sm4_datapath.sv
rtl/sm4_block_cipher_ecb_cbc_core.sv
tb/sm4_block_cipher_ecb_cbc_core_tb.sv
